### src/psbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbf_pkg
// Shared types and codes for the packet stream byte FIFO.
// ----------------------------------------------------------------------------
package psbf_pkg;

  localparam int DATA_W     = 8;
  localparam int LEN_W      = 11;
  localparam int CAP_W      = 13;
  localparam int STAT_W     = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int S_TDATA_W  = 24;   // data_in, packet_length, first_of_request, pad
  localparam int M_TDATA_W  = 24;   // data_out, free_bytes, pad

  // Result status codes
  localparam logic [STAT_W-1:0] ST_READ      = 3'd0;
  localparam logic [STAT_W-1:0] ST_WRITE_OK  = 3'd1;
  localparam logic [STAT_W-1:0] ST_SIZE_REJ  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STAT_W-1:0] ST_PKT_ENDED = 3'd5;

  // Transaction kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PKT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PKT  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PKT_MODE = 2'd3;

  // Register reset values
  localparam logic [CAP_W-1:0] CAP_RESET  = 13'd4096;
  localparam logic [LEN_W-1:0] MAXP_RESET = 11'd1024;
  localparam logic [LEN_W-1:0] MINP_RESET = 11'd1;

  // Hard packet length limit
  localparam logic [LEN_W-1:0] MAX_PACKET_BYTES = 11'd1024;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  plen;
    logic              first;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic              eop;
    logic [CAP_W-1:0]  free;
  } result_t;

endpackage

### src/psbf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbf_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module psbf_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/psbf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbf_ctrl
// Pointer/count state, config registers, two-step item sequencer, output reg.
// ----------------------------------------------------------------------------
module psbf_ctrl
  import psbf_pkg::*;
#(
  parameter int BUF_BYTES = 4096,
  localparam int AW = $clog2(BUF_BYTES),
  localparam int CW = $clog2(BUF_BYTES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  // config
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CAP_W-1:0]      cfg_wdata,
  // item in
  input  logic                  s_valid,
  output logic                  s_ready,
  input  item_t                 s_item,
  // result out
  output logic                  m_valid,
  input  logic                  m_ready,
  output result_t               m_res,
  // byte memory
  output logic                  mem_re,
  output logic                  byte_we,
  output logic [AW-1:0]         byte_waddr,
  output logic [DATA_W-1:0]     byte_wdata,
  output logic [AW-1:0]         byte_raddr,
  input  logic [DATA_W-1:0]     byte_rdata,
  // length memory
  output logic                  len_we,
  output logic [AW-1:0]         len_waddr,
  output logic [LEN_W-1:0]      len_wdata,
  output logic [AW-1:0]         len_raddr,
  input  logic [LEN_W-1:0]      len_rdata
);

  localparam int PW = (CW > LEN_W) ? CW : LEN_W;
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;
  localparam int SW = ((AW > LEN_W) ? AW : LEN_W) + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_ACCEPT     = 2'd1;
  localparam logic [1:0] PH_DROP_SIZE  = 2'd2;
  localparam logic [1:0] PH_DROP_SPACE = 2'd3;

  // config registers
  logic [CAP_W-1:0] capacity;
  logic [LEN_W-1:0] max_pkt;
  logic [LEN_W-1:0] min_pkt;
  logic             pkt_mode;

  // sequencer and held item
  logic  state;
  item_t it;

  // FIFO state
  logic [AW-1:0]    head_ptr,     head_ptr_next;
  logic [AW-1:0]    tail_ptr,     tail_ptr_next;
  logic [AW-1:0]    head_idx,     head_idx_next;
  logic [AW-1:0]    tail_idx,     tail_idx_next;
  logic [LEN_W-1:0] offset,       offset_next;
  logic [CW-1:0]    occupied,     occupied_next;
  logic [CW-1:0]    ready_cnt,    ready_cnt_next;
  logic [LEN_W-1:0] wr_remaining, wr_remaining_next;
  logic [1:0]       wr_phase,     wr_phase_next;
  logic             read_ended,   read_ended_next;
  result_t          res_next;

  logic             accept;
  logic             fire;
  logic [CW-1:0]    cap_clamp;
  logic [CW-1:0]    free_now;
  logic [CW-1:0]    free_after;
  logic [LEN_W-1:0] rem_dec;
  logic [LEN_W-1:0] off_inc;
  logic [LEN_W-1:0] skip_len;
  logic [AW-1:0]    head_inc;
  logic [SW-1:0]    skip_sum;
  logic             ended_eff;
  logic             bad_size;
  logic             release_pkt;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    ring_inc = (p == AW'(BUF_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [CW-1:0] free_of(input logic [CW-1:0] cap,
                                            input logic [CW-1:0] occ);
    free_of = (cap > occ) ? cap - occ : '0;
  endfunction

  assign s_ready = (state == S_IDLE);
  assign accept  = s_valid && s_ready;
  assign fire    = (state == S_EXEC) && (!m_valid || m_ready);

  // reads are launched at accept, data lands for the execute cycle
  assign mem_re     = accept;
  assign byte_raddr = head_ptr;
  assign len_raddr  = head_idx;

  assign cap_clamp = (MW'(capacity) > MW'(BUF_BYTES)) ? CW'(BUF_BYTES) : CW'(capacity);
  assign free_now  = free_of(cap_clamp, occupied);

  always_comb begin
    head_ptr_next     = head_ptr;
    tail_ptr_next     = tail_ptr;
    head_idx_next     = head_idx;
    tail_idx_next     = tail_idx;
    offset_next       = offset;
    occupied_next     = occupied;
    ready_cnt_next    = ready_cnt;
    wr_remaining_next = wr_remaining;
    wr_phase_next     = wr_phase;
    read_ended_next   = read_ended;
    res_next.status   = ST_SIZE_REJ;
    res_next.data     = '0;
    res_next.eop      = 1'b0;
    byte_we           = 1'b0;
    byte_waddr        = tail_ptr;
    byte_wdata        = it.data;
    len_we            = 1'b0;
    len_waddr         = tail_idx;
    len_wdata         = it.plen;
    rem_dec           = (wr_remaining != '0) ? wr_remaining - 1'b1 : '0;
    off_inc           = offset + 1'b1;
    head_inc          = ring_inc(head_ptr);
    skip_len          = len_rdata - off_inc;
    skip_sum          = SW'(head_inc) + SW'(skip_len);
    ended_eff         = it.first ? 1'b0 : read_ended;
    release_pkt       = 1'b0;
    bad_size          = (it.plen == '0) || (it.plen > MAX_PACKET_BYTES) ||
                        (it.plen < min_pkt) || (it.plen > max_pkt);

    if (skip_sum >= SW'(BUF_BYTES)) begin
      skip_sum = skip_sum - SW'(BUF_BYTES);
    end

    if (it.kind == KIND_WRITE) begin
      if (wr_phase != PH_IDLE) begin
        // continuation byte of an open packet
        if (wr_phase == PH_ACCEPT) begin
          byte_we         = 1'b1;
          tail_ptr_next   = ring_inc(tail_ptr);
          res_next.status = ST_WRITE_OK;
        end else if (wr_phase == PH_DROP_SIZE) begin
          res_next.status = ST_SIZE_REJ;
        end else begin
          res_next.status = ST_NO_SPACE;
        end
        wr_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          if (wr_phase == PH_ACCEPT) begin
            ready_cnt_next = ready_cnt + 1'b1;
            tail_idx_next  = ring_inc(tail_idx);
          end
          wr_phase_next = PH_IDLE;
        end
      end else if (!it.first) begin
        res_next.status = ST_SIZE_REJ;          // stray byte
      end else if (bad_size || (PW'(free_now) < PW'(it.plen))) begin
        res_next.status = bad_size ? ST_SIZE_REJ : ST_NO_SPACE;
        if (it.plen > 11'd1) begin
          wr_phase_next     = bad_size ? PH_DROP_SIZE : PH_DROP_SPACE;
          wr_remaining_next = it.plen - 1'b1;
        end
      end else begin
        res_next.status = ST_WRITE_OK;
        occupied_next   = occupied + CW'(it.plen);
        len_we          = 1'b1;
        byte_we         = 1'b1;
        tail_ptr_next   = ring_inc(tail_ptr);
        if (it.plen == 11'd1) begin
          ready_cnt_next = ready_cnt + 1'b1;
          tail_idx_next  = ring_inc(tail_idx);
        end else begin
          wr_phase_next     = PH_ACCEPT;
          wr_remaining_next = it.plen - 1'b1;
        end
      end
    end else begin
      read_ended_next = ended_eff;
      if (pkt_mode && ended_eff) begin
        res_next.status = ST_PKT_ENDED;
      end else if (ready_cnt == '0) begin
        res_next.status = ST_EMPTY;
      end else begin
        res_next.status = ST_READ;
        res_next.data   = byte_rdata;
        head_ptr_next   = head_inc;
        offset_next     = off_inc;
        if (off_inc >= len_rdata) begin
          res_next.eop = 1'b1;
          release_pkt  = 1'b1;
        end else if (pkt_mode && it.last) begin
          // drop the unread tail of the packet
          head_ptr_next = AW'(skip_sum);
          release_pkt   = 1'b1;
        end
      end
      if (release_pkt) begin
        occupied_next  = (occupied > CW'(len_rdata)) ? occupied - CW'(len_rdata) : '0;
        head_idx_next  = ring_inc(head_idx);
        ready_cnt_next = (ready_cnt != '0) ? ready_cnt - 1'b1 : '0;
        offset_next    = '0;
        if (pkt_mode) begin
          read_ended_next = 1'b1;
        end
      end
      if (pkt_mode && it.last) begin
        read_ended_next = 1'b1;
      end
    end

    if (!fire) begin
      byte_we = 1'b0;
      len_we  = 1'b0;
    end

    free_after    = free_of(cap_clamp, occupied_next);
    res_next.free = CAP_W'(free_after);
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      max_pkt  <= MAXP_RESET;
      min_pkt  <= MINP_RESET;
      pkt_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CAPACITY: capacity <= cfg_wdata;
        REG_MAX_PKT:  max_pkt  <= cfg_wdata[LEN_W-1:0];
        REG_MIN_PKT:  min_pkt  <= cfg_wdata[LEN_W-1:0];
        REG_PKT_MODE: pkt_mode <= cfg_wdata[0];
        default:      pkt_mode <= pkt_mode;
      endcase
    end
  end

  // sequencer, state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_valid      <= 1'b0;
      head_ptr     <= '0;
      tail_ptr     <= '0;
      head_idx     <= '0;
      tail_idx     <= '0;
      offset       <= '0;
      occupied     <= '0;
      ready_cnt    <= '0;
      wr_remaining <= '0;
      wr_phase     <= PH_IDLE;
      read_ended   <= 1'b0;
    end else begin
      if (accept) begin
        state <= S_EXEC;
      end else if (fire) begin
        state        <= S_IDLE;
        head_ptr     <= head_ptr_next;
        tail_ptr     <= tail_ptr_next;
        head_idx     <= head_idx_next;
        tail_idx     <= tail_idx_next;
        offset       <= offset_next;
        occupied     <= occupied_next;
        ready_cnt    <= ready_cnt_next;
        wr_remaining <= wr_remaining_next;
        wr_phase     <= wr_phase_next;
        read_ended   <= read_ended_next;
      end
      if (fire) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      it <= s_item;
    end
    if (fire) begin
      m_res <= res_next;
    end
  end

endmodule

### src/packet_stream_byte_fifo_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_stream_byte_fifo_core
// Packet byte FIFO with stream and packet read modes, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one byte per transaction. tuser selects write (0) or read
//   (1), tlast marks the reader's final byte of a request, tdata holds the
//   write byte, the packet length (taken on a packet's first byte) and the
//   start-of-request flag. Every transaction yields exactly one result on
//   the master stream: status in tuser, end of packet in tlast, read byte and
//   the free byte count after the transaction in tdata.
//   Config registers (capacity, max/min packet, packet mode) are written via
//   cfg_we/cfg_addr/cfg_wdata while no transaction is in flight.
// Timing:
//   Memory reads launch at acceptance; the execute step then runs the read-
//   modify-write and loads the output register that drives m_tvalid. A new
//   transaction is not accepted until the previous one has executed, since
//   the memories have a registered read.
// Reset: rst (sync) empties the FIFO and restores register defaults; memory
//   contents are not cleared and need no clearing pass.
// Stall: a held result holds the execute step; one more transaction is
//   accepted, then s_tready stays low until the held result is taken.
// ----------------------------------------------------------------------------
module packet_stream_byte_fifo_core
  import psbf_pkg::*;
#(
  parameter int BUF_BYTES = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CAP_W-1:0]      cfg_wdata,
  // slave stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] data_in, [18:8] packet_length,
                                           // [19] first_of_request, [23:20] zero
  input  logic                  s_tuser,   // [0] kind
  input  logic                  s_tlast,   // last_of_request
  // master stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] data_out, [20:8] free_bytes,
                                           // [23:21] zero
  output logic [STAT_W-1:0]     m_tuser,   // [2:0] status
  output logic                  m_tlast    // end_of_packet
);

  localparam int AW = $clog2(BUF_BYTES);

  item_t   s_item;
  result_t m_res;

  logic              mem_re;
  logic              byte_we;
  logic [AW-1:0]     byte_waddr;
  logic [DATA_W-1:0] byte_wdata;
  logic [AW-1:0]     byte_raddr;
  logic [DATA_W-1:0] byte_rdata;
  logic              len_we;
  logic [AW-1:0]     len_waddr;
  logic [LEN_W-1:0]  len_wdata;
  logic [AW-1:0]     len_raddr;
  logic [LEN_W-1:0]  len_rdata;

  // unpack the incoming transaction
  assign s_item.kind  = s_tuser;
  assign s_item.data  = s_tdata[7:0];
  assign s_item.plen  = s_tdata[18:8];
  assign s_item.first = s_tdata[19];
  assign s_item.last  = s_tlast;

  // pack the result
  assign m_tdata = {{(M_TDATA_W - DATA_W - CAP_W){1'b0}}, m_res.free, m_res.data};
  assign m_tuser = m_res.status;
  assign m_tlast = m_res.eop;

  psbf_ctrl #(
    .BUF_BYTES (BUF_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_item     (s_item),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .m_res      (m_res),
    .mem_re     (mem_re),
    .byte_we    (byte_we),
    .byte_waddr (byte_waddr),
    .byte_wdata (byte_wdata),
    .byte_raddr (byte_raddr),
    .byte_rdata (byte_rdata),
    .len_we     (len_we),
    .len_waddr  (len_waddr),
    .len_wdata  (len_wdata),
    .len_raddr  (len_raddr),
    .len_rdata  (len_rdata)
  );

  // packet bytes, ring addressed by byte pointers
  psbf_ram #(
    .DEPTH (BUF_BYTES),
    .WIDTH (DATA_W)
  ) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (byte_wdata),
    .re    (mem_re),
    .raddr (byte_raddr),
    .rdata (byte_rdata)
  );

  // packet lengths, ring addressed by packet index
  psbf_ram #(
    .DEPTH (BUF_BYTES),
    .WIDTH (LEN_W)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (mem_re),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

endmodule

### src/psbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbf_checker
// Port-level checks for the packet stream byte FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module psbf_checker
  import psbf_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_TDATA_W-1:0]  m_tdata,
  input logic [STAT_W-1:0]     m_tuser,
  input logic                  m_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result changed while stalled");

  // one transaction in flight at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a transaction while one is executing");

  // a fresh result rises only after an accepted transaction
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without matching transaction");

  // end of packet only on a byte read
  a_eop_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == ST_READ)
    else $error("end of packet on non-read result");

  // no data on non-read results
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_READ) |-> m_tdata[7:0] == '0)
    else $error("data on non-read result");

endmodule

bind packet_stream_byte_fifo_core psbf_checker u_psbf_checker (.*);
